// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property that is checked only while out of reset.
`define QRI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property that is checked during reset too.
`define QRI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/qri_pkg.sv -----
// Package for the quaternion rate integrator: widths, stage counts, side-data type.
// Depends on nothing.
package qri_pkg;

    localparam int MAG_W     = 30;   // normalized magnitude width
    localparam int SQ_W      = 62;   // sum of four squared magnitudes
    localparam int SQ_STAGES = 32;   // one result bit per stage
    localparam int ROOT_W    = 31;   // root of a value below 2^62
    localparam int QUO_W     = 17;   // quotient below 2^17
    localparam int REM_W     = 48;   // remainder width in the divider
    localparam int OUT_FRAC  = 14;

    typedef struct packed {
        logic                       degen;
        logic [3:0]                 neg;
        logic [3:0][MAG_W-1:0]      mag;
    } qri_side_t;

endpackage

// ----- hdl/qri_isqrt.sv -----
// Fully pipelined integer square root, one result bit per stage, with side data.
// Depends on qri_pkg.
module qri_isqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qri_pkg::SQ_W-1:0]    in_sq,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [qri_pkg::ROOT_W-1:0]  out_root,
    output logic [SIDE_W-1:0]           out_side
);
    import qri_pkg::*;

    logic [63:0]       v_reg     [1:SQ_STAGES];
    logic [63:0]       res_reg   [1:SQ_STAGES];
    logic [SIDE_W-1:0] side_reg  [1:SQ_STAGES];
    logic              valid_reg [1:SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]       v_cur, res_cur, v_next, res_next, trial;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;

        if (k == 0) begin : g_first
            assign v_cur     = {{(64-SQ_W){1'b0}}, in_sq};
            assign res_cur   = '0;
            assign side_cur  = in_side;
            assign valid_cur = in_valid;
        end else begin : g_rest
            assign v_cur     = v_reg[k];
            assign res_cur   = res_reg[k];
            assign side_cur  = side_reg[k];
            assign valid_cur = valid_reg[k];
        end

        always_comb
        begin
            trial = res_cur + BIT;
            if (v_cur >= trial)
            begin
                v_next   = v_cur - trial;
                res_next = (res_cur >> 1) + BIT;
            end
            else
            begin
                v_next   = v_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k+1]    <= v_next;
                res_reg[k+1]  <= res_next;
                side_reg[k+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[SQ_STAGES];
    assign out_root  = res_reg[SQ_STAGES][ROOT_W-1:0];
    assign out_side  = side_reg[SQ_STAGES];

endmodule

// ----- hdl/qri_div.sv -----
// Pipelined restoring divider: four rounded quotients over a common root, one bit a stage.
// Depends on qri_pkg.
module qri_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [qri_pkg::ROOT_W-1:0]          in_root,
    input  qri_pkg::qri_side_t                  in_side,
    output logic                                out_valid,
    output logic [3:0][qri_pkg::QUO_W-1:0]      out_quo,
    output logic [3:0]                          out_neg,
    output logic                                out_degen
);
    import qri_pkg::*;

    logic [3:0][REM_W-1:0] rem_reg   [1:QUO_W];
    logic [3:0][QUO_W-1:0] quo_reg   [1:QUO_W];
    logic [ROOT_W-1:0]     den_reg   [1:QUO_W];
    logic [3:0]            neg_reg   [1:QUO_W];
    logic                  degen_reg [1:QUO_W];
    logic                  valid_reg [1:QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int SH = QUO_W - 1 - j;
        logic [3:0][REM_W-1:0] rem_cur, rem_next;
        logic [3:0][QUO_W-1:0] quo_cur, quo_next;
        logic [ROOT_W-1:0]     den_cur;
        logic [REM_W-1:0]      den_sh;
        logic [3:0]            neg_cur;
        logic                  degen_cur, valid_cur;

        if (j == 0) begin : g_first
            for (genvar l = 0; l < 4; l++) begin : g_num
                assign rem_cur[l] = {{(REM_W-MAG_W-OUT_FRAC){1'b0}}, in_side.mag[l],
                                     {OUT_FRAC{1'b0}}}
                                    + {{(REM_W-ROOT_W+1){1'b0}}, in_root[ROOT_W-1:1]};
            end
            assign quo_cur   = '0;
            assign den_cur   = in_root;
            assign neg_cur   = in_side.neg;
            assign degen_cur = in_side.degen;
            assign valid_cur = in_valid;
        end else begin : g_rest
            assign rem_cur   = rem_reg[j];
            assign quo_cur   = quo_reg[j];
            assign den_cur   = den_reg[j];
            assign neg_cur   = neg_reg[j];
            assign degen_cur = degen_reg[j];
            assign valid_cur = valid_reg[j];
        end

        assign den_sh = {{(REM_W-ROOT_W){1'b0}}, den_cur} << SH;

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                quo_next[l] = quo_cur[l];
                if (rem_cur[l] >= den_sh)
                begin
                    rem_next[l]     = rem_cur[l] - den_sh;
                    quo_next[l][SH] = 1'b1;
                end
                else
                begin
                    rem_next[l] = rem_cur[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j+1] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]   <= rem_next;
                quo_reg[j+1]   <= quo_next;
                den_reg[j+1]   <= den_cur;
                neg_reg[j+1]   <= neg_cur;
                degen_reg[j+1] <= degen_cur;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_neg   = neg_reg[QUO_W];
    assign out_degen = degen_reg[QUO_W];

endmodule

// ----- hdl/quaternion_rate_integrator_unit.sv -----
// Top level of the quaternion rate integrator: rate product, step sum, renormalization.
// Depends on qri_pkg, qri_isqrt and qri_div.

// Takes one item (quaternion q in Q1.14, rate omega in Q5.10) per clock and returns
// q + (time_step/2) * ((omega,0) * q), scaled to unit length and rounded to Q1.14.
// The pipeline is 59 register stages deep: nine for the products, the step sum and
// block normalization, 32 for the square root (one root bit per stage), 17 for the
// divider (one quotient bit per stage) and the output register. Throughput is one
// item per cycle; when out_ready is low with a result waiting, the whole pipeline
// holds and in_ready drops in the same cycle, so nothing is lost or repeated.
// A sum of exactly zero length gives a zero quaternion with degenerate set.
// time_step resets to 655 (about 10 ms) and is written through cfg_we/cfg_wdata; the user
// writes it only while the pipeline is empty, which the block itself does not enforce.
module quaternion_rate_integrator_unit #(
    parameter logic [15:0] TIME_STEP_RESET = 16'd655
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] q_x,
    input  logic signed [15:0] q_y,
    input  logic signed [15:0] q_z,
    input  logic signed [15:0] q_w,
    input  logic signed [15:0] omega_x,
    input  logic signed [15:0] omega_y,
    input  logic signed [15:0] omega_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y,
    output logic signed [15:0] new_z,
    output logic signed [15:0] new_w,
    output logic               degenerate
);
    import qri_pkg::*;

    logic [15:0] time_step_reg;
    logic        en;
    logic        out_valid_reg;

    // Advance whenever the output register is empty or being taken.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_we)
        begin
            time_step_reg <= cfg_wdata;
        end
    end

    // Valid bits for stages 1..9.
    logic [9:1] v_reg;

    // Stage 1: the twelve raw products of the Hamilton product.
    logic signed [31:0]        p_reg [12];
    logic signed [3:0][15:0]   q1_reg;
    // Stage 2: dq components at scale 2^24.
    logic signed [33:0]        dq_reg [4];
    logic signed [3:0][15:0]   q2_reg;
    // Stage 3: dq times the step.
    logic signed [50:0]        t_reg [4];
    logic signed [3:0][15:0]   q3_reg;
    // Stage 4: s = q * 2^27 + dq * step.
    logic signed [51:0]        s_reg [4];
    // Stage 5: sign and magnitude.
    logic [3:0][50:0]          mag5_reg;
    logic [3:0]                neg5_reg;
    // Stage 6: bit length of the largest magnitude.
    logic [5:0]                len6_reg;
    logic                      degen6_reg;
    logic [3:0][50:0]          mag6_reg;
    logic [3:0]                neg6_reg;
    // Stage 7: magnitudes shifted to the common block scale.
    qri_side_t                 side7_reg;
    // Stage 8: squares.
    logic [MAG_W*2-1:0]        sqr8_reg [4];
    qri_side_t                 side8_reg;
    // Stage 9: sum of squares.
    logic [SQ_W-1:0]           sum9_reg;
    qri_side_t                 side9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:1], in_valid};
        end
    end

    // Combinational pieces between stages.
    logic [50:0]       or_mag;
    logic [5:0]        len_next;
    logic [3:0][50:0]  mag_next;
    logic [3:0]        neg_next;
    qri_side_t         side7_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = s_reg[i][51];
            mag_next[i] = neg_next[i] ? 51'(-s_reg[i]) : s_reg[i][50:0];
        end
    end

    assign or_mag = mag5_reg[0] | mag5_reg[1] | mag5_reg[2] | mag5_reg[3];

    // Priority encode: bit length of the largest magnitude.
    always_comb
    begin
        len_next = '0;
        for (int b = 0; b < 51; b++)
        begin
            if (or_mag[b])
            begin
                len_next = 6'(b + 1);
            end
        end
    end

    always_comb
    begin
        side7_next.degen = degen6_reg;
        side7_next.neg   = neg6_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (len6_reg > 6'(MAG_W))
            begin
                side7_next.mag[i] = MAG_W'(mag6_reg[i] >> (len6_reg - 6'(MAG_W)));
            end
            else
            begin
                side7_next.mag[i] = MAG_W'(mag6_reg[i] << (6'(MAG_W) - len6_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= q_w * omega_x;
            p_reg[1]  <= omega_y * q_z;
            p_reg[2]  <= omega_z * q_y;
            p_reg[3]  <= q_w * omega_y;
            p_reg[4]  <= omega_z * q_x;
            p_reg[5]  <= omega_x * q_z;
            p_reg[6]  <= q_w * omega_z;
            p_reg[7]  <= omega_x * q_y;
            p_reg[8]  <= omega_y * q_x;
            p_reg[9]  <= omega_x * q_x;
            p_reg[10] <= omega_y * q_y;
            p_reg[11] <= omega_z * q_z;
            q1_reg    <= {q_w, q_z, q_y, q_x};

            dq_reg[0] <= 34'(p_reg[0]) + 34'(p_reg[1]) - 34'(p_reg[2]);
            dq_reg[1] <= 34'(p_reg[3]) + 34'(p_reg[4]) - 34'(p_reg[5]);
            dq_reg[2] <= 34'(p_reg[6]) + 34'(p_reg[7]) - 34'(p_reg[8]);
            dq_reg[3] <= -(34'(p_reg[9]) + 34'(p_reg[10]) + 34'(p_reg[11]));
            q2_reg    <= q1_reg;

            for (int i = 0; i < 4; i++)
            begin
                t_reg[i] <= dq_reg[i] * $signed({1'b0, time_step_reg});
                // Element selects are unsigned; sign-extend q explicitly.
                s_reg[i] <= (52'($signed(q3_reg[i])) <<< 27) + 52'(t_reg[i]);
                sqr8_reg[i] <= side7_reg.mag[i] * side7_reg.mag[i];
            end
            q3_reg <= q2_reg;

            mag5_reg <= mag_next;
            neg5_reg <= neg_next;

            len6_reg   <= len_next;
            degen6_reg <= (or_mag == '0);
            mag6_reg   <= mag5_reg;
            neg6_reg   <= neg5_reg;

            side7_reg <= side7_next;
            side8_reg <= side7_reg;

            sum9_reg  <= SQ_W'(sqr8_reg[0]) + SQ_W'(sqr8_reg[1])
                       + SQ_W'(sqr8_reg[2]) + SQ_W'(sqr8_reg[3]);
            side9_reg <= side8_reg;
        end
    end

    // Square root of the sum of squares.
    logic                      sq_valid;
    logic [ROOT_W-1:0]         sq_root;
    qri_side_t                 sq_side;

    qri_isqrt #(
        .SIDE_W ($bits(qri_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[9]),
        .in_sq     (sum9_reg),
        .in_side   (side9_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Rounded division of each magnitude by the root.
    logic                      dv_valid;
    logic [3:0][QUO_W-1:0]     dv_quo;
    logic [3:0]                dv_neg;
    logic                      dv_degen;

    qri_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg),
        .out_degen (dv_degen)
    );

    // Saturate, apply sign, zero a degenerate item.
    logic [3:0][15:0] res_next;
    logic [3:0][15:0] res_reg;
    logic             degen_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dv_degen)
            begin
                res_next[i] = '0;
            end
            else if (dv_neg[i])
            begin
                res_next[i] = (dv_quo[i] > QUO_W'(32768)) ? 16'h8000 : 16'(-dv_quo[i]);
            end
            else
            begin
                res_next[i] = (dv_quo[i] > QUO_W'(32767)) ? 16'h7fff : dv_quo[i][15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= res_next;
            degen_reg <= dv_degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_x      = res_reg[0];
    assign new_y      = res_reg[1];
    assign new_z      = res_reg[2];
    assign new_w      = res_reg[3];
    assign degenerate = degen_reg;

endmodule

// ----- hdl/qri_checker.sv -----
// Port-level checker for the quaternion rate integrator, bound to the top level.
// Depends on assert_macros.svh and quaternion_rate_integrator_unit.
`include "assert_macros.svh"

module qri_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] new_x,
    input logic signed [15:0] new_y,
    input logic signed [15:0] new_z,
    input logic signed [15:0] new_w,
    input logic               degenerate
);

    // A held result stays valid and keeps new_x, new_w and degenerate until taken.
    `QRI_ASSERT(a_hold_result, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(new_w) && $stable(degenerate), "stalled result changed")

    // A degenerate item carries a zero quaternion.
    `QRI_ASSERT(a_degen_zero, clk, rst_n, out_valid && degenerate |-> new_x == 16'sd0 && new_y == 16'sd0 && new_z == 16'sd0 && new_w == 16'sd0, "degenerate item not zero")

    // Input side stalls exactly when a result waits unread.
    `QRI_ASSERT(a_ready_follows, clk, rst_n, in_ready == (!out_valid || out_ready), "input ready does not track output stall")

    // Nothing is valid at the output while reset is held.
    `QRI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind quaternion_rate_integrator_unit qri_checker u_qri_checker (.*);
